### sv/gsa_pkg.sv
// Package for the generational slot allocator.
// Default sizes, operation, status and register index codes.
// No dependencies.
package gsa_pkg;

    localparam int SLOTS_DEF        = 1024;
    localparam int BUFFER_BYTES_DEF = 4096;

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_RELEASE  = 2'd1,
        OP_IDENTIFY = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_OPEN  = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_IGNORED   = 3'd3,
        ST_NO_MATCH  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CFG_POOL_OPEN    = 2'd0,
        CFG_BASE_ADDRESS = 2'd1,
        CFG_DEVICE_TAG   = 2'd2,
        CFG_POOL_TAG     = 2'd3
    } cfg_idx_t;

endpackage

### sv/gsa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/generational_slot_allocator.sv
// Failures decided at accept give a result in the cycle after; allocate, release and identify
// read the slot memory, then register the result in S_EXEC, where allocate and a matching
// release write the entry back; when BUFFER_BYTES is not a power of two, identify first passes
// S_DIV (reciprocal multiply for the slot) and S_RD (a check that the offset is a whole number
// of buffers), where a misaligned offset is reported. A new item is taken only once the last is through.
// Reset: synchronous, active low; then a clearing pass writes every slot memory entry, during
// which s_ready stays low. Depends on gsa_pkg and gsa_ram.
module generational_slot_allocator
    import gsa_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_slot_number,
    input  logic [31:0] s_handle_generation,
    input  logic [63:0] s_query_address,
    input  logic [31:0] s_query_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [9:0]  m_result_slot,
    output logic [31:0] m_result_generation,
    output logic [63:0] m_buffer_address,
    output logic [15:0] m_match_device,
    output logic [63:0] m_match_pool
);

    localparam int SW              = $clog2(SLOTS + 1);
    localparam int AW              = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MW              = 1 + 32 + SW;
    localparam int LOG2            = $clog2(BUFFER_BYTES);
    localparam bit IS_POW2         = ((64'd1 << LOG2) == 64'(BUFFER_BYTES));
    localparam logic [63:0] TOTAL  = 64'(SLOTS) * 64'(BUFFER_BYTES);
    localparam logic [63:0] AMASK  = 64'(BUFFER_BYTES) - 64'd1;
    localparam int OW              = $clog2(TOTAL + 64'd1);
    localparam int PW              = SW + $clog2(BUFFER_BYTES + 1);
    localparam int RW              = OW - LOG2 + 2;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << OW) + 64'(BUFFER_BYTES) - 64'd1) / 64'(BUFFER_BYTES));

    typedef enum logic [4:0] {
        S_INIT = 5'b00001,
        S_IDLE = 5'b00010,
        S_DIV  = 5'b00100,
        S_RD   = 5'b01000,
        S_EXEC = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic          pool_open_reg;
    logic [63:0]   base_reg;
    logic [15:0]   dev_reg;
    logic [63:0]   pool_reg;

    logic [SW-1:0] init_reg, init_next;
    logic [SW-1:0] head_reg, head_next;
    op_t           op_reg, op_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [31:0]   hgen_reg, hgen_next;
    logic [OW-1:0] rem_reg, rem_next;

    logic          m_valid_reg, m_valid_next;
    status_t       status_reg, status_next;
    logic [9:0]    rslot_reg, rslot_next;
    logic [31:0]   rgen_reg, rgen_next;
    logic [63:0]   baddr_reg, baddr_next;
    logic [15:0]   mdev_reg, mdev_next;
    logic [63:0]   mpool_reg, mpool_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [MW-1:0] ram_wdata, ram_rdata;

    logic          rd_alloc;
    logic [31:0]   rd_gen;
    logic [SW-1:0] rd_link;
    logic [31:0]   gen_inc;
    logic [PW-1:0] prod;
    logic [OW+RW-1:0] recip_prod;

    logic [63:0]   off;
    logic          id_ok;
    logic [SW-1:0] id_slot;
    logic          rel_range;

    logic          out_load;
    status_t       out_status;
    logic [9:0]    out_slot;
    logic [31:0]   out_gen;
    logic [63:0]   out_addr;
    logic [15:0]   out_dev;
    logic [63:0]   out_pool;

    gsa_ram #(
        .WIDTH (MW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // entry layout: {allocated, generation, next link}
    assign rd_alloc = ram_rdata[MW-1];
    assign rd_gen   = ram_rdata[MW-2 -: 32];
    assign rd_link  = ram_rdata[SW-1:0];
    assign gen_inc  = rd_gen + 32'd1;
    assign prod     = PW'(slot_reg) * PW'(BUFFER_BYTES);
    // exact for every whole multiple of BUFFER_BYTES below TOTAL
    assign recip_prod = (OW+RW)'(rem_reg) * (OW+RW)'(RECIP);

    assign off       = s_query_address - base_reg;
    assign id_slot   = SW'(off >> LOG2);
    assign id_ok     = (s_query_length == 32'(BUFFER_BYTES)) && (s_query_address >= base_reg)
                    && (off < TOTAL) && (!IS_POW2 || ((off & AMASK) == 64'd0));
    assign rel_range = ({1'b0, s_slot_number} < 17'(SLOTS));

    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        init_next    = init_reg;
        head_next    = head_reg;
        op_next      = op_reg;
        slot_next    = slot_reg;
        hgen_next    = hgen_reg;
        rem_next     = rem_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        rslot_next   = rslot_reg;
        rgen_next    = rgen_reg;
        baddr_next   = baddr_reg;
        mdev_next    = mdev_reg;
        mpool_next   = mpool_reg;

        ram_we     = 1'b0;
        ram_waddr  = slot_reg[AW-1:0];
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = head_reg[AW-1:0];

        out_load   = 1'b0;
        out_status = ST_OK;
        out_slot   = '0;
        out_gen    = '0;
        out_addr   = '0;
        out_dev    = '0;
        out_pool   = '0;

        case (state_reg)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = init_reg[AW-1:0];
                ram_wdata = {1'b0, 32'd1, SW'(init_reg + SW'(1))};
                init_next = SW'(init_reg + SW'(1));
                if (init_reg == SW'(SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    op_next   = op_t'(s_operation);
                    hgen_next = s_handle_generation;
                    case (op_t'(s_operation))
                        OP_ALLOC: begin
                            if (!pool_open_reg) begin
                                out_load   = 1'b1;
                                out_status = ST_NOT_OPEN;
                            end else if (head_reg == SW'(SLOTS)) begin
                                out_load   = 1'b1;
                                out_status = ST_EXHAUSTED;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = head_reg[AW-1:0];
                                slot_next  = head_reg;
                                state_next = S_EXEC;
                            end
                        end
                        OP_RELEASE: begin
                            if (!rel_range) begin
                                out_load   = 1'b1;
                                out_status = ST_IGNORED;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(s_slot_number);
                                slot_next  = SW'(s_slot_number);
                                state_next = S_EXEC;
                            end
                        end
                        OP_IDENTIFY: begin
                            if (!id_ok) begin
                                out_load   = 1'b1;
                                out_status = ST_NO_MATCH;
                            end else if (IS_POW2) begin
                                ram_re     = 1'b1;
                                ram_raddr  = id_slot[AW-1:0];
                                slot_next  = id_slot;
                                state_next = S_EXEC;
                            end else begin
                                rem_next   = OW'(off);
                                state_next = S_DIV;
                            end
                        end
                        default: begin
                            out_load   = 1'b1;
                            out_status = ST_NO_MATCH;
                        end
                    endcase
                end
            end
            S_DIV: begin
                slot_next  = SW'(recip_prod >> OW);
                state_next = S_RD;
            end
            S_RD: begin
                if (prod != PW'(rem_reg)) begin
                    out_load   = 1'b1;
                    out_status = ST_NO_MATCH;
                    state_next = S_IDLE;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot_reg[AW-1:0];
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                out_load   = 1'b1;
                state_next = S_IDLE;
                case (op_reg)
                    OP_ALLOC: begin
                        ram_we     = 1'b1;
                        ram_wdata  = {1'b1, rd_gen, rd_link};
                        head_next  = rd_link;
                        out_status = ST_OK;
                        out_slot   = 10'(slot_reg);
                        out_gen    = rd_gen;
                        out_addr   = base_reg + 64'(prod);
                    end
                    OP_RELEASE: begin
                        if (rd_alloc && (rd_gen == hgen_reg)) begin
                            ram_we     = 1'b1;
                            ram_wdata  = {1'b0, gen_inc, head_reg};
                            head_next  = slot_reg;
                            out_status = ST_OK;
                            out_slot   = 10'(slot_reg);
                            out_gen    = gen_inc;
                        end else begin
                            out_status = ST_IGNORED;
                        end
                    end
                    OP_IDENTIFY: begin
                        if (rd_alloc) begin
                            out_status = ST_OK;
                            out_slot   = 10'(slot_reg);
                            out_gen    = rd_gen;
                            out_dev    = dev_reg;
                            out_pool   = pool_reg;
                        end else begin
                            out_status = ST_NO_MATCH;
                        end
                    end
                    default: begin
                        out_status = ST_NO_MATCH;
                    end
                endcase
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
            status_next  = out_status;
            rslot_next   = out_slot;
            rgen_next    = out_gen;
            baddr_next   = out_addr;
            mdev_next    = out_dev;
            mpool_next   = out_pool;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            init_reg      <= '0;
            head_reg      <= '0;
            m_valid_reg   <= 1'b0;
            pool_open_reg <= 1'b1;
            base_reg      <= '0;
            dev_reg       <= '0;
            pool_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_POOL_OPEN:    pool_open_reg <= cfg_data[0];
                    CFG_BASE_ADDRESS: base_reg      <= cfg_data;
                    CFG_DEVICE_TAG:   dev_reg       <= cfg_data[15:0];
                    CFG_POOL_TAG:     pool_reg      <= cfg_data;
                    default:          pool_reg      <= pool_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        slot_reg   <= slot_next;
        hgen_reg   <= hgen_next;
        rem_reg    <= rem_next;
        status_reg <= status_next;
        rslot_reg  <= rslot_next;
        rgen_reg   <= rgen_next;
        baddr_reg  <= baddr_next;
        mdev_reg   <= mdev_next;
        mpool_reg  <= mpool_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = status_reg;
    assign m_result_slot       = rslot_reg;
    assign m_result_generation = rgen_reg;
    assign m_buffer_address    = baddr_reg;
    assign m_match_device      = mdev_reg;
    assign m_match_pool        = mpool_reg;

endmodule

### sv/gsa_checker.sv
// Port-level checks for the generational slot allocator, bound to the top level.
// Depends on gsa_pkg.
module gsa_checker
    import gsa_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [9:0]  m_result_slot,
    input logic [31:0] m_result_generation,
    input logic [63:0] m_buffer_address,
    input logic [15:0] m_match_device,
    input logic [63:0] m_match_pool
);

    // stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_result_slot)
            && $stable(m_result_generation) && $stable(m_buffer_address))
        else $error("result item changed while stalled");

    // no new item while a result waits
    a_no_accept_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input ready while result stalled");

    // failed items carry only a status
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_result_slot == '0)
            && (m_result_generation == '0) && (m_buffer_address == '0)
            && (m_match_device == '0) && (m_match_pool == '0))
        else $error("failed result with nonzero fields");

    // clearing pass holds off input after reset
    a_init_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_ready)
        else $error("input ready during clearing pass");

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (.*);
